FILE: design/tlpt_pkg.sv
// Shared constants and types for the two-level page table engine.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package tlpt_pkg;

  // Pool size default and fixed table geometry
  localparam int NUM_TABLES_DEF = 16;
  localparam int ENTRIES        = 1024;
  localparam int IDX_W          = 10;
  localparam int OFF_W          = 12;
  localparam int ADDR_W         = 32;
  localparam int FRAME_W        = ADDR_W - OFF_W;
  localparam int FLAG_W         = 12;
  localparam int ACT_W          = 2;
  localparam int DIR_LSB        = 22;
  localparam int TBL_LSB        = 12;
  localparam int FLAG_USER_BIT  = 2;

  // Request opcodes; code 3 is a no-op and has no member
  typedef enum logic [ACT_W-1:0] {
    ACT_MAP   = 2'd0,
    ACT_UNMAP = 2'd1,
    ACT_XLATE = 2'd2
  } act_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_DCLR,   // directory clearing after reset
    ST_IDLE,   // waiting for a request
    ST_DIR,    // directory entry read data available
    ST_SCLR,   // clearing a newly allocated table
    ST_TBL,    // page entry read data available
    ST_DONE    // result waiting for the output register
  } state_t;

endpackage

`default_nettype wire

FILE: design/tlpt_req_if.sv
// Request channel: valid/ready handshake with map/unmap/translate payload.
// Depends on tlpt_pkg for field widths.
`default_nettype none

interface tlpt_req_if;
  logic                        valid;
  logic                        ready;
  logic [tlpt_pkg::ACT_W-1:0]  action;
  logic [tlpt_pkg::ADDR_W-1:0] virt_addr;
  logic [tlpt_pkg::ADDR_W-1:0] phys_addr;
  logic [tlpt_pkg::FLAG_W-1:0] page_flags;

  modport source (output valid, action, virt_addr, phys_addr, page_flags, input ready);
  modport sink   (input valid, action, virt_addr, phys_addr, page_flags, output ready);
endinterface

`default_nettype wire

FILE: design/tlpt_rsp_if.sv
// Response channel: valid/ready handshake with translation result and status.
// Depends on tlpt_pkg for field widths.
`default_nettype none

interface tlpt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tlpt_pkg::ADDR_W-1:0] translated_addr;
  logic                        found;
  logic                        status;

  modport source (output valid, translated_addr, found, status, input ready);
  modport sink   (input valid, translated_addr, found, status, output ready);
endinterface

`default_nettype wire

FILE: design/two_level_page_table_engine.sv
// Two-level page table engine: directory RAM, table pool RAM and sequencer.
// Depends on tlpt_pkg, tlpt_req_if and tlpt_rsp_if.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+--------------------------------------------
//  req     | in  | valid/ready | action, virt_addr, phys_addr, page_flags
//  rsp     | out | valid/ready | translated_addr, found, status
//
// Map, unmap, no-op and a translate whose directory entry is absent pass through
// ST_DIR and ST_DONE from accept to response; a translate whose directory entry is
// present also passes ST_TBL (directory read, then pool read, each a synchronous RAM read).
// A map that allocates a table also clears that table in the pool (ST_SCLR).
// After reset the directory is cleared one entry per cycle, with ready held low.
// One request is in flight at a time; ready is low until its response is loaded
// into the output register, which waits there while rsp.ready is low.
`default_nettype none

module two_level_page_table_engine #(
  parameter int NUM_TABLES = tlpt_pkg::NUM_TABLES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tlpt_req_if.sink   req,
  tlpt_rsp_if.source rsp
);

  localparam int IDX_W      = tlpt_pkg::IDX_W;
  localparam int OFF_W      = tlpt_pkg::OFF_W;
  localparam int FRAME_W    = tlpt_pkg::FRAME_W;
  localparam int ADDR_W     = tlpt_pkg::ADDR_W;
  localparam int SLOT_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int CNT_W      = $clog2(NUM_TABLES + 1);
  localparam int DIR_DEPTH  = 1 << IDX_W;
  localparam int POOL_DEPTH = NUM_TABLES * tlpt_pkg::ENTRIES;
  localparam int POOL_AW    = $clog2(POOL_DEPTH);

  typedef struct packed {
    logic              present;
    logic              writable;
    logic              user;
    logic [SLOT_W-1:0] slot;
  } dir_ent_t;

  // Only the frame and present bit of a page entry are ever read back
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
  } pg_ent_t;

  tlpt_pkg::state_t state, state_next;

  logic [IDX_W-1:0]  sweep, sweep_next;
  logic [CNT_W-1:0]  next_free, next_free_next;
  logic [SLOT_W-1:0] cur_slot, cur_slot_next;

  // Captured request
  logic [tlpt_pkg::ACT_W-1:0] act;
  logic [IDX_W-1:0]           didx;
  logic [IDX_W-1:0]           tidx;
  logic [OFF_W-1:0]           offset;
  logic [FRAME_W-1:0]         frame_in;
  logic                       user_in;

  // Pending result
  logic [ADDR_W-1:0] res_taddr, res_taddr_next;
  logic              res_found, res_found_next;
  logic              res_status, res_status_next;

  // Output register
  logic              out_valid;
  logic [ADDR_W-1:0] out_taddr;
  logic              out_found;
  logic              out_status;
  logic              out_load;

  logic req_ready;
  logic accept;

  // RAM ports
  dir_ent_t dir_mem [DIR_DEPTH];
  dir_ent_t dir_rdata;
  dir_ent_t dir_wdata;
  logic [IDX_W-1:0] dir_waddr;
  logic             dir_we;

  pg_ent_t pool_mem [POOL_DEPTH];
  pg_ent_t pool_rdata;
  pg_ent_t pool_wdata;
  pg_ent_t pg_in;
  logic [SLOT_W+IDX_W-1:0] pool_full;
  logic [POOL_AW-1:0]      pool_addr;
  logic                    pool_we;
  logic                    pool_re;

  assign accept    = req.valid && req_ready;
  assign req.ready = req_ready;
  assign pg_in     = '{frame: frame_in, present: 1'b1};
  assign pool_addr = pool_full[POOL_AW-1:0];

  assign rsp.valid           = out_valid;
  assign rsp.translated_addr = out_taddr;
  assign rsp.found           = out_found;
  assign rsp.status          = out_status;

  // Directory RAM: read issued on the accepting edge
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (accept) begin
      dir_rdata <= dir_mem[req.virt_addr[ADDR_W-1:tlpt_pkg::DIR_LSB]];
    end
  end

  // Table pool RAM
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_addr] <= pool_wdata;
    end
    if (pool_re) begin
      pool_rdata <= pool_mem[pool_addr];
    end
  end

  // State register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlpt_pkg::ST_DCLR;
      sweep     <= '0;
      next_free <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      next_free <= next_free_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= req.action;
      didx     <= req.virt_addr[ADDR_W-1:tlpt_pkg::DIR_LSB];
      tidx     <= req.virt_addr[tlpt_pkg::DIR_LSB-1:tlpt_pkg::TBL_LSB];
      offset   <= req.virt_addr[OFF_W-1:0];
      frame_in <= req.phys_addr[ADDR_W-1:OFF_W];
      user_in  <= req.page_flags[tlpt_pkg::FLAG_USER_BIT];
    end
    cur_slot   <= cur_slot_next;
    res_taddr  <= res_taddr_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_taddr  <= res_taddr;
      out_found  <= res_found;
      out_status <= res_status;
    end
  end

  // Sequencer: next state and RAM controls
  always_comb begin
    state_next      = state;
    sweep_next      = sweep;
    next_free_next  = next_free;
    cur_slot_next   = cur_slot;
    res_taddr_next  = res_taddr;
    res_found_next  = res_found;
    res_status_next = res_status;
    req_ready       = 1'b0;
    out_load        = 1'b0;
    dir_we          = 1'b0;
    dir_waddr       = sweep;
    dir_wdata       = '0;
    pool_we         = 1'b0;
    pool_re         = 1'b0;
    pool_full       = {cur_slot, sweep};
    pool_wdata      = '0;

    case (state)
      tlpt_pkg::ST_DCLR: begin
        dir_we     = 1'b1;
        sweep_next = sweep + IDX_W'(1);
        if (sweep == '1) begin
          state_next = tlpt_pkg::ST_IDLE;
        end
      end

      tlpt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          state_next = tlpt_pkg::ST_DIR;
        end
      end

      tlpt_pkg::ST_DIR: begin
        res_taddr_next  = '0;
        res_found_next  = 1'b0;
        res_status_next = 1'b0;
        state_next      = tlpt_pkg::ST_DONE;
        case (act)
          tlpt_pkg::ACT_MAP: begin
            if (dir_rdata.present) begin
              pool_we    = 1'b1;
              pool_full  = {dir_rdata.slot, tidx};
              pool_wdata = pg_in;
            end else if (next_free >= CNT_W'(NUM_TABLES)) begin
              res_status_next = 1'b1;
            end else begin
              // allocate the next slot, then clear it and place the entry
              dir_we         = 1'b1;
              dir_waddr      = didx;
              dir_wdata      = '{present: 1'b1, writable: 1'b1, user: user_in,
                                 slot: SLOT_W'(next_free)};
              next_free_next = next_free + CNT_W'(1);
              cur_slot_next  = SLOT_W'(next_free);
              sweep_next     = '0;
              state_next     = tlpt_pkg::ST_SCLR;
            end
          end
          tlpt_pkg::ACT_UNMAP: begin
            if (dir_rdata.present) begin
              pool_we   = 1'b1;
              pool_full = {dir_rdata.slot, tidx};
            end
          end
          tlpt_pkg::ACT_XLATE: begin
            if (dir_rdata.present) begin
              pool_re    = 1'b1;
              pool_full  = {dir_rdata.slot, tidx};
              state_next = tlpt_pkg::ST_TBL;
            end
          end
          default: ;
        endcase
      end

      tlpt_pkg::ST_SCLR: begin
        pool_we    = 1'b1;
        pool_wdata = (sweep == tidx) ? pg_in : '0;
        sweep_next = sweep + IDX_W'(1);
        if (sweep == '1) begin
          state_next = tlpt_pkg::ST_DONE;
        end
      end

      tlpt_pkg::ST_TBL: begin
        if (pool_rdata.present) begin
          res_taddr_next = {pool_rdata.frame, offset};
          res_found_next = 1'b1;
        end
        state_next = tlpt_pkg::ST_DONE;
      end

      tlpt_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = tlpt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tlpt_pkg::ST_DCLR;
      end
    endcase
  end

  // Checks
  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while another is in flight");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= CNT_W'(NUM_TABLES))
    else $error("allocator ran past the pool");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == tlpt_pkg::ST_DONE))
    else $error("response appeared without a finished request");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.status))
    else $error("translation found together with map failure");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == tlpt_pkg::ST_IDLE) |-> (!pool_we && !dir_we))
    else $error("RAM write while idle");

endmodule

`default_nettype wire

FILE: tb/two_level_page_table_engine_tb.sv
// Self-checking testbench for two_level_page_table_engine: map, unmap and
// translate requests checked against a software page walk kept in the bench.
// Depends on tlpt_pkg, tlpt_req_if, tlpt_rsp_if and the engine itself.
`timescale 1ns / 100ps

module two_level_page_table_engine_tb;

  localparam int ACT_W         = tlpt_pkg::ACT_W;
  localparam int ADDR_W        = tlpt_pkg::ADDR_W;
  localparam int FLAG_W        = tlpt_pkg::FLAG_W;
  localparam int OFF_W         = tlpt_pkg::OFF_W;
  localparam int IDX_W         = tlpt_pkg::IDX_W;
  localparam int ENTRIES       = tlpt_pkg::ENTRIES;
  localparam int DIR_LSB       = tlpt_pkg::DIR_LSB;
  localparam int TBL_LSB       = tlpt_pkg::TBL_LSB;

  localparam int NUM_TABLES    = tlpt_pkg::NUM_TABLES_DEF;
  localparam int RANDOM_ITEMS  = 1930;
  localparam int CALM_ITEMS    = 250;     // tail of the run with no idling
  localparam int DIR_CHOICES   = 24;      // more directories than table slots
  localparam int HOT_PAGES     = 48;
  localparam int HOLD_AFTER    = 400;     // responses before the long stall
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_PRINTS    = 100;

  // action code 3 has no package member: the engine treats it as a no-op
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] virt;
    logic [ADDR_W-1:0] phys;
    logic [FLAG_W-1:0] flags;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic              status;
  } page_rsp_t;

  logic clk;
  logic rst;

  tlpt_req_if req_ch ();
  tlpt_rsp_if rsp_ch ();

  two_level_page_table_engine #(
    .NUM_TABLES(NUM_TABLES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow page table
  logic              dir_present [ENTRIES];
  int                dir_slot    [ENTRIES];
  logic [ADDR_W-1:0] pool_entry  [NUM_TABLES * ENTRIES];
  int                slots_used;

  page_req_t req_backlog [$];
  page_rsp_t due_rsps    [$];
  page_req_t on_bus;
  logic [19:0] hot_vpns [$];
  logic [IDX_W-1:0] dir_choice [DIR_CHOICES];

  int   err_count;
  int   rsp_count;
  int   cycles;
  int   send_gap;
  int   rsp_stall;
  logic calm;
  logic hold_rsp;

  task automatic report_mismatch(string msg);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  // Walk the shadow tables for one request and update them
  function automatic page_rsp_t run_page_op(page_req_t r);
    page_rsp_t        o;
    logic [IDX_W-1:0] di;
    logic [IDX_W-1:0] ti;
    logic [ADDR_W-1:0] te;
    o  = '0;
    di = r.virt[DIR_LSB +: IDX_W];
    ti = r.virt[TBL_LSB +: IDX_W];
    case (r.action)
      tlpt_pkg::ACT_MAP: begin
        // absent directory entry takes the next slot, if any is left
        if (!dir_present[di] && slots_used < NUM_TABLES) begin
          for (int k = 0; k < ENTRIES; k++) begin
            pool_entry[slots_used * ENTRIES + k] = '0;
          end
          dir_present[di] = 1'b1;
          dir_slot[di]    = slots_used;
          slots_used++;
        end
        if (dir_present[di]) begin
          pool_entry[dir_slot[di] * ENTRIES + ti] =
            {r.phys[ADDR_W-1:OFF_W], r.flags | 12'h001};
        end else begin
          o.status = 1'b1;
        end
      end
      tlpt_pkg::ACT_UNMAP: begin
        if (dir_present[di]) begin
          pool_entry[dir_slot[di] * ENTRIES + ti] = '0;
        end
      end
      tlpt_pkg::ACT_XLATE: begin
        if (dir_present[di]) begin
          te = pool_entry[dir_slot[di] * ENTRIES + ti];
          if (te[0]) begin
            o.addr  = {te[ADDR_W-1:OFF_W], r.virt[OFF_W-1:0]};
            o.found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic queue_req(logic [ACT_W-1:0] a, logic [ADDR_W-1:0] v,
                           logic [ADDR_W-1:0] p, logic [FLAG_W-1:0] f);
    page_req_t r;
    r.action = a;
    r.virt   = v;
    r.phys   = p;
    r.flags  = f;
    req_backlog.push_back(r);
  endtask

  // Virtual page number, mostly inside the small set of directories
  function automatic logic [19:0] fresh_vpn();
    logic [IDX_W-1:0] d;
    logic [IDX_W-1:0] t;
    if ($urandom_range(0, 9) == 0) begin
      d = IDX_W'($urandom_range(0, ENTRIES - 1));
    end else begin
      d = dir_choice[$urandom_range(0, DIR_CHOICES - 1)];
    end
    t = IDX_W'($urandom_range(0, ENTRIES - 1));
    return {d, t};
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      calm         <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        due_rsps.push_back(run_page_op(on_bus));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          send_gap = int'($urandom_range(0, 13));
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          on_bus = req_backlog.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.action     <= on_bus.action;
          req_ch.virt_addr  <= on_bus.virt;
          req_ch.phys_addr  <= on_bus.phys;
          req_ch.page_flags <= on_bus.flags;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      calm <= (req_backlog.size() <= CALM_ITEMS);
    end
  end

  // Response monitor and ready control
  always @(posedge clk) begin
    page_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_count++;
        if (due_rsps.size() == 0) begin
          report_mismatch($sformatf("response %0d with nothing outstanding", rsp_count));
        end else begin
          want = due_rsps.pop_front();
          if (rsp_ch.translated_addr !== want.addr) begin
            report_mismatch($sformatf("response %0d translated_addr %h, want %h",
                                      rsp_count, rsp_ch.translated_addr, want.addr));
          end
          if (rsp_ch.found !== want.found) begin
            report_mismatch($sformatf("response %0d found %b, want %b",
                                      rsp_count, rsp_ch.found, want.found));
          end
          if (rsp_ch.status !== want.status) begin
            report_mismatch($sformatf("response %0d status %b, want %b",
                                      rsp_count, rsp_ch.status, want.status));
          end
        end
      end
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rsp_stall = int'($urandom_range(0, 13));
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall so the engine backs up onto its request port
  initial begin
    hold_rsp = 1'b0;
    wait (rsp_count >= HOLD_AFTER);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** two_level_page_table_engine: FAILED **");
      $finish;
    end
  end

  // Stimulus and end of test
  initial begin
    int          roll;
    logic [19:0] vpn;
    logic [11:0] off;
    clk               = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.action     = '0;
    req_ch.virt_addr  = '0;
    req_ch.phys_addr  = '0;
    req_ch.page_flags = '0;
    rsp_ch.ready      = 1'b0;
    err_count  = 0;
    rsp_count  = 0;
    cycles     = 0;
    send_gap   = 0;
    rsp_stall  = 0;
    slots_used = 0;
    for (int k = 0; k < ENTRIES; k++) begin
      dir_present[k] = 1'b0;
      dir_slot[k]    = 0;
    end
    for (int k = 0; k < NUM_TABLES * ENTRIES; k++) begin
      pool_entry[k] = '0;
    end
    dir_choice[0] = '0;
    dir_choice[1] = '1;
    for (int k = 2; k < DIR_CHOICES; k++) begin
      dir_choice[k] = IDX_W'($urandom_range(0, ENTRIES - 1));
    end

    // Directed: empty lookup, field extremes, remap, unmap, no-op
    queue_req(tlpt_pkg::ACT_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_MAP,   32'h0000_0ABC, 32'hFFFF_FFFF, 12'hFFF);
    queue_req(tlpt_pkg::ACT_XLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_MAP,   32'hFFFF_F000, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    queue_req(tlpt_pkg::ACT_MAP,   32'h003F_F123, 32'h1234_5FFF, 12'h006);
    queue_req(tlpt_pkg::ACT_XLATE, 32'h003F_F000, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_MAP,   32'h0000_0000, 32'hA5A5_A000, 12'h004);
    queue_req(tlpt_pkg::ACT_XLATE, 32'h0000_0555, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_UNMAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    queue_req(tlpt_pkg::ACT_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_UNMAP, 32'h8000_0000, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_XLATE, 32'h8000_0000, 32'h0000_0000, 12'h000);
    queue_req(ACT_NOP,             32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    queue_req(tlpt_pkg::ACT_XLATE, 32'hFFFF_F001, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_UNMAP, 32'hFFFF_F000, 32'h0000_0000, 12'h000);
    queue_req(tlpt_pkg::ACT_XLATE, 32'hFFFF_F000, 32'h0000_0000, 12'h000);
    // flags without the present bit still yield a present entry
    queue_req(tlpt_pkg::ACT_MAP,   32'h0010_0000, 32'h5A5A_5000, 12'hAAA);
    queue_req(tlpt_pkg::ACT_XLATE, 32'h0010_0ABC, 32'h0000_0000, 12'h000);
    queue_req(ACT_NOP,             32'h0000_0000, 32'h0000_0000, 12'h000);

    // Random: map pages, then mostly look up and drop pages already mapped;
    // the directory set outgrows the pool so maps run out of slots
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = int'($urandom_range(0, 99));
      off  = OFF_W'($urandom_range(0, 4095));
      if (hot_vpns.size() != 0 && $urandom_range(0, 4) != 0) begin
        vpn = hot_vpns[$urandom_range(0, hot_vpns.size() - 1)];
      end else begin
        vpn = fresh_vpn();
      end
      if (roll < 4) begin
        queue_req(ACT_W'($urandom_range(0, 3)), $urandom, $urandom,
                  FLAG_W'($urandom_range(0, 4095)));
      end else if (roll < 40) begin
        if (roll < 28) begin
          vpn = fresh_vpn();
        end
        queue_req(tlpt_pkg::ACT_MAP, {vpn, off}, $urandom,
                  FLAG_W'($urandom_range(0, 4095)));
        hot_vpns.push_back(vpn);
        if (hot_vpns.size() > HOT_PAGES) begin
          void'(hot_vpns.pop_front());
        end
      end else if (roll < 82) begin
        queue_req(tlpt_pkg::ACT_XLATE, {vpn, off}, $urandom,
                  FLAG_W'($urandom_range(0, 4095)));
      end else begin
        queue_req(tlpt_pkg::ACT_UNMAP, {vpn, off}, $urandom,
                  FLAG_W'($urandom_range(0, 4095)));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // one more edge so the last request is on the bus before the drain check
    wait (req_backlog.size() == 0);
    @(posedge clk);
    while (req_ch.valid || due_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("** two_level_page_table_engine: PASSED **");
    end else begin
      $display("** two_level_page_table_engine: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tlpt_pkg.sv
design/tlpt_req_if.sv
design/tlpt_rsp_if.sv
design/two_level_page_table_engine.sv
tb/two_level_page_table_engine_tb.sv
